/* rtl/aes_cmac_tag_engine_defines.svh */
// Assertion macros for the AES-CMAC tag engine.
// Used by the top level; no dependencies.
`ifndef AES_CMAC_TAG_ENGINE_DEFINES_SVH
`define AES_CMAC_TAG_ENGINE_DEFINES_SVH
`define ACMAC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ACMAC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* rtl/acmac_pkg.sv */
// Package for the AES-CMAC tag engine: types, S-box, round helpers.
// No dependencies.
`default_nettype none
package acmac_pkg;
    localparam int BLK_W = 128;
    localparam int NUM_LANES = 16;
    localparam int NUM_ROUNDS = 10;
    localparam logic [7:0] GF_RED = 8'h87;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [0:0] REG_KEY_HI = 1'b0;
    localparam logic [0:0] REG_KEY_LO = 1'b1;

    typedef logic [BLK_W-1:0] blk_t;
    typedef logic [3:0] rnd_t;

    typedef struct packed {
        logic final_rnd;
    } rnd_ctl_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] tbl [256];
        tbl = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return tbl[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input rnd_t r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01;
            4'd2: v = 8'h02;
            4'd3: v = 8'h04;
            4'd4: v = 8'h08;
            4'd5: v = 8'h10;
            4'd6: v = 8'h20;
            4'd7: v = 8'h40;
            4'd8: v = 8'h80;
            4'd9: v = 8'h1b;
            4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // byte i of a block, byte 0 most significant
    function automatic logic [7:0] get_byte(input blk_t b, input int i);
        return b[BLK_W-1-8*i -: 8];
    endfunction

    function automatic blk_t dbl(input blk_t a);
        return {a[BLK_W-2:0], 1'b0} ^ (a[BLK_W-1] ? blk_t'(GF_RED) : blk_t'(0));
    endfunction

    function automatic blk_t next_rkey(input blk_t k, input rnd_t r);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction
endpackage
`default_nettype wire

/* rtl/acmac_if.sv */
// Valid/ready channel interface, payload by type parameter.
// No dependencies.
`default_nettype none
interface acmac_if #(parameter type PAYLOAD_T = logic) ();
    logic valid;
    logic ready;
    PAYLOAD_T payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* rtl/acmac_lane.sv */
// One column lane of an AES round: SubBytes, MixColumn, AddRoundKey.
// Depends on acmac_pkg.
`default_nettype none
module acmac_lane
    import acmac_pkg::*;
(
    input  wire logic [31:0] col_in,
    input  wire logic [31:0] rkey,
    input  wire logic        final_rnd,
    output logic      [31:0] col_out
);
    logic [7:0] a0, a1, a2, a3, all;
    logic [31:0] mixed;
    always_comb
    begin
        a0 = sbox(col_in[31:24]);
        a1 = sbox(col_in[23:16]);
        a2 = sbox(col_in[15:8]);
        a3 = sbox(col_in[7:0]);
        all = a0 ^ a1 ^ a2 ^ a3;
        if (final_rnd)
            mixed = {a0, a1, a2, a3};
        else
            mixed = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                     a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
        col_out = mixed ^ rkey;
    end
endmodule
`default_nettype wire

/* rtl/acmac_round.sv */
// AES round: ShiftRows feeds four column lanes, outputs merged into the state.
// Depends on acmac_pkg, acmac_lane.
`default_nettype none
module acmac_round
    import acmac_pkg::*;
(
    input  wire blk_t     state_in,
    input  wire blk_t     rkey,
    input  wire rnd_ctl_t ctl,
    output blk_t          state_out
);
    logic [31:0] cols [4];
    logic [31:0] outs [4];
    always_comb
    begin
        for (int c = 0; c < 4; c++)
            cols[c] = {get_byte(state_in, ((c + 0) % 4) * 4 + 0),
                       get_byte(state_in, ((c + 1) % 4) * 4 + 1),
                       get_byte(state_in, ((c + 2) % 4) * 4 + 2),
                       get_byte(state_in, ((c + 3) % 4) * 4 + 3)};
    end
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        acmac_lane u_lane (
            .col_in(cols[g]),
            .rkey(rkey[127-32*g -: 32]),
            .final_rnd(ctl.final_rnd),
            .col_out(outs[g])
        );
    end
    assign state_out = {outs[0], outs[1], outs[2], outs[3]};
endmodule
`default_nettype wire

/* rtl/aes_cmac_tag_engine.sv */
// Top level of the AES-128 CMAC tag engine: control, key schedule, tag output.
// Depends on acmac_pkg, acmac_if, acmac_round and the defines header.
`default_nettype none
`include "aes_cmac_tag_engine_defines.svh"
// An AES-128 pass loads the state, then runs ten rounds on one round unit
// with an on-the-fly key schedule. Each block is loaded, run through ten rounds
// and its result stored before the next transaction is accepted; the first
// block after reset or a key write runs the subkey pass first.
// The round unit is the only loop, so blocks are serialized by CBC chaining.
// The tag sits in an output register, so the next block is taken while a tag
// waits; a second tag stalls until the first one has left.
module aes_cmac_tag_engine
    import acmac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    acmac_if.sink            in_ch,
    acmac_if.source          out_ch
);
    typedef enum logic [1:0] {ST_IDLE, ST_SUBKEY, ST_RUN} state_t;

    state_t state_reg;
    logic [63:0] key_hi_reg, key_lo_reg;
    blk_t chain_reg, k1_reg, k2_reg, st_reg, rk_reg, blk_reg, exp_reg;
    logic ready_sk_reg, last_reg;
    rnd_t rnd_reg;
    logic ovalid_reg, omatch_reg;
    blk_t otag_reg;
    logic [4:0] nvsave_reg;

    blk_t key_w, rnd_out, rk_next, din, padded, msg, l_next, pad_s;
    logic [4:0] nv;
    rnd_ctl_t ctl;
    logic take, done, out_free;

    assign key_w = {key_hi_reg, key_lo_reg};
    assign out_free = !ovalid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && rst_n;
    assign take = in_ch.valid && in_ch.ready;
    assign done = (state_reg == ST_RUN) && (rnd_reg == rnd_t'(NUM_ROUNDS));
    assign rk_next = next_rkey(rk_reg, rnd_t'(rnd_reg + 4'd1));
    assign ctl.final_rnd = (rnd_reg == rnd_t'(NUM_ROUNDS - 1));

    acmac_round u_round (
        .state_in(st_reg),
        .rkey(rk_next),
        .ctl(ctl),
        .state_out(rnd_out)
    );

    assign din = {in_ch.payload.data_hi, in_ch.payload.data_lo};
    assign nv = in_ch.payload.valid_bytes;
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            if (nv[4] || i < int'(nv[3:0]))
                padded[BLK_W-1-8*i -: 8] = get_byte(din, i);
            else if (i == int'(nv[3:0]))
                padded[BLK_W-1-8*i -: 8] = PAD_BYTE;
            else
                padded[BLK_W-1-8*i -: 8] = 8'h00;
        end
    end
    assign l_next = dbl(rnd_out);

    // message block, with the subkey XOR on the last block; subkeys must be ready
    function automatic blk_t prep(input blk_t k1, input blk_t k2);
        if (!in_ch.payload.last)
            return din;
        else if (nv[4])
            return din ^ k1;
        else
            return padded ^ k2;
    endfunction
    always_comb
    begin
        msg = prep(k1_reg, k2_reg);
    end

    // saved last-block shaping, used after the subkey pass
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            if (nvsave_reg[4] || i < int'(nvsave_reg[3:0]))
                pad_s[BLK_W-1-8*i -: 8] = get_byte(blk_reg, i);
            else if (i == int'(nvsave_reg[3:0]))
                pad_s[BLK_W-1-8*i -: 8] = PAD_BYTE;
            else
                pad_s[BLK_W-1-8*i -: 8] = 8'h00;
        end
    end
    function automatic blk_t prep2(input blk_t k1);
        if (!last_reg)
            return blk_reg;
        else if (nvsave_reg[4])
            return blk_reg ^ k1;
        else
            return pad_s ^ dbl(k1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            key_hi_reg <= '0;
            key_lo_reg <= '0;
            chain_reg <= '0;
            k1_reg <= '0;
            k2_reg <= '0;
            st_reg <= '0;
            rk_reg <= '0;
            blk_reg <= '0;
            exp_reg <= '0;
            nvsave_reg <= '0;
            ready_sk_reg <= 1'b0;
            rnd_reg <= '0;
            ovalid_reg <= 1'b0;
            omatch_reg <= 1'b0;
            otag_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ready_sk_reg <= 1'b0;
                if (cfg_index == REG_KEY_HI)
                    key_hi_reg <= cfg_data;
                else
                    key_lo_reg <= cfg_data;
            end
            if (ovalid_reg && out_ch.ready && !(done && last_reg))
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        blk_reg <= din;
                        exp_reg <= {in_ch.payload.expected_tag_hi,
                                    in_ch.payload.expected_tag_lo};
                        last_reg <= in_ch.payload.last;
                        nvsave_reg <= nv;
                        rk_reg <= key_w;
                        rnd_reg <= '0;
                        if (ready_sk_reg)
                        begin
                            st_reg <= chain_reg ^ msg ^ key_w;
                            state_reg <= ST_RUN;
                        end
                        else
                        begin
                            st_reg <= key_w;
                            state_reg <= ST_SUBKEY;
                        end
                    end
                end
                ST_SUBKEY:
                begin
                    if (rnd_reg == rnd_t'(NUM_ROUNDS - 1))
                    begin
                        k1_reg <= l_next;
                        k2_reg <= dbl(l_next);
                        if (!cfg_we)
                            ready_sk_reg <= 1'b1;
                        rnd_reg <= '0;
                        rk_reg <= key_w;
                        st_reg <= chain_reg ^ prep2(l_next) ^ key_w;
                        state_reg <= ST_RUN;
                    end
                    else
                    begin
                        st_reg <= rnd_out;
                        rk_reg <= rk_next;
                        rnd_reg <= rnd_reg + 4'd1;
                    end
                end
                ST_RUN:
                begin
                    if (rnd_reg != rnd_t'(NUM_ROUNDS))
                    begin
                        st_reg <= rnd_out;
                        rk_reg <= rk_next;
                        rnd_reg <= rnd_reg + 4'd1;
                    end
                    else if (!last_reg)
                    begin
                        chain_reg <= st_reg;
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        chain_reg <= '0;
                        otag_reg <= st_reg;
                        omatch_reg <= (st_reg == exp_reg);
                        ovalid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload.tag_hi = otag_reg[127:64];
    assign out_ch.payload.tag_lo = otag_reg[63:0];
    assign out_ch.payload.tag_match = omatch_reg;

    `ACMAC_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == ST_IDLE)
    `ACMAC_ASSERT_NXT(a_run_after_sk, clk, rst_n,
        state_reg == ST_SUBKEY && rnd_reg == rnd_t'(NUM_ROUNDS - 1), state_reg == ST_RUN)
    `ACMAC_ASSERT_IMP(a_rnd_range, clk, rst_n, state_reg != ST_IDLE,
        rnd_reg <= rnd_t'(NUM_ROUNDS))
    `ACMAC_ASSERT_NXT(a_tag_hold, clk, rst_n, out_ch.valid && !out_ch.ready,
        out_ch.valid && $stable(otag_reg))
    `ACMAC_ASSERT_IMP(a_done_ok, clk, rst_n, done && !last_reg, !take)
endmodule
`default_nettype wire
